@@ design/tnna_pkg.sv @@
// tnna_pkg: shared types and fixed field widths of the triangle normal and area unit
// used by triangle_unit_normal_and_area, tnna_isqrt and tnna_udiv; no dependencies
`default_nettype none

package tnna_pkg;

    localparam int OUT_W    = 16;
    localparam int AREA_W   = 33;
    localparam int MINLEN_W = 34;

    // stage control handed to each pipelined unit
    typedef struct packed {
        logic adv;
        logic vld;
    } pipe_ctl_t;

endpackage

`default_nettype wire

@@ design/tnna_isqrt.sv @@
// tnna_isqrt: pipelined integer square root, one result bit per stage
// carries a side payload alongside the radicand; uses tnna_pkg
`default_nettype none

module tnna_isqrt
    import tnna_pkg::*;
#(
    parameter int ROOT_W = 34,
    parameter int SIDE_W = 8
)
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  pipe_ctl_t                ctl,
    input  wire  [2*ROOT_W-1:0]      rad,
    input  wire  [SIDE_W-1:0]        side,
    output logic [ROOT_W-1:0]        root,
    output logic [SIDE_W-1:0]        side_out,
    output logic                     vld_out
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;

    logic [RAD_W-1:0]  rad_w  [0:ROOT_W];
    logic [REM_W-1:0]  rem_w  [0:ROOT_W];
    logic [ROOT_W-1:0] root_w [0:ROOT_W];
    logic [SIDE_W-1:0] side_w [0:ROOT_W];
    logic              vld_w  [0:ROOT_W];

    assign rad_w[0]  = rad;
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign side_w[0] = side;
    assign vld_w[0]  = ctl.vld;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;
        logic [RAD_W-1:0]  rad_reg;
        logic [REM_W-1:0]  rem_reg;
        logic [ROOT_W-1:0] root_reg;
        logic [SIDE_W-1:0] side_reg;
        logic              vld_reg;

        assign rem_sh = {rem_w[k][REM_W-3:0], rad_w[k][RAD_W-1 -: 2]};
        assign trial  = {1'b0, root_w[k], 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (ctl.adv)
            begin
                vld_reg <= vld_w[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.adv)
            begin
                rad_reg  <= {rad_w[k][RAD_W-3:0], 2'b00};
                rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_w[k][ROOT_W-2:0], ge};
                side_reg <= side_w[k];
            end
        end

        assign rad_w[k+1]  = rad_reg;
        assign rem_w[k+1]  = rem_reg;
        assign root_w[k+1] = root_reg;
        assign side_w[k+1] = side_reg;
        assign vld_w[k+1]  = vld_reg;
    end

    assign root     = root_w[ROOT_W];
    assign side_out = side_w[ROOT_W];
    assign vld_out  = vld_w[ROOT_W];

endmodule

`default_nettype wire

@@ design/tnna_udiv.sv @@
// tnna_udiv: three-lane pipelined restoring divider, one quotient bit per stage
// all lanes share one divisor and a side payload; uses tnna_pkg
`default_nettype none

module tnna_udiv
    import tnna_pkg::*;
#(
    parameter int LEN_W  = 34,
    parameter int QF     = 15,
    parameter int SIDE_W = 8
)
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  pipe_ctl_t                  ctl,
    input  wire  [2:0][LEN_W-1:0]      mag,
    input  wire  [LEN_W-1:0]           len,
    input  wire  [SIDE_W-1:0]          side,
    output logic [2:0][QF:0]           quot,
    output logic [2:0][LEN_W:0]        rem,
    output logic [LEN_W-1:0]           len_out,
    output logic [SIDE_W-1:0]          side_out,
    output logic                       vld_out
);

    localparam int RW = LEN_W + 1;
    localparam int NS = QF + 1;

    logic [2:0][RW-1:0] rem_w  [0:NS];
    logic [2:0][QF:0]   q_w    [0:NS];
    logic [LEN_W-1:0]   len_w  [0:NS];
    logic [SIDE_W-1:0]  side_w [0:NS];
    logic               vld_w  [0:NS];

    for (genvar l = 0; l < 3; l++) begin : g_in
        assign rem_w[0][l] = {1'b0, mag[l]};
        assign q_w[0][l]   = '0;
    end
    assign len_w[0]  = len;
    assign side_w[0] = side;
    assign vld_w[0]  = ctl.vld;

    for (genvar j = 0; j < NS; j++) begin : g_step
        logic [2:0][RW-1:0] rem_next;
        logic [2:0][QF:0]   q_next;
        logic [2:0][RW-1:0] rem_reg;
        logic [2:0][QF:0]   q_reg;
        logic [LEN_W-1:0]   len_reg;
        logic [SIDE_W-1:0]  side_reg;
        logic               vld_reg;

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                logic [RW-1:0] r;
                if (j == 0)
                begin
                    r = rem_w[j][l];
                end
                else
                begin
                    r = {rem_w[j][l][RW-2:0], 1'b0};
                end
                if (r >= {1'b0, len_w[j]})
                begin
                    rem_next[l] = r - {1'b0, len_w[j]};
                    q_next[l]   = {q_w[j][l][QF-1:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = r;
                    q_next[l]   = {q_w[j][l][QF-1:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (ctl.adv)
            begin
                vld_reg <= vld_w[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ctl.adv)
            begin
                rem_reg  <= rem_next;
                q_reg    <= q_next;
                len_reg  <= len_w[j];
                side_reg <= side_w[j];
            end
        end

        assign rem_w[j+1]  = rem_reg;
        assign q_w[j+1]    = q_reg;
        assign len_w[j+1]  = len_reg;
        assign side_w[j+1] = side_reg;
        assign vld_w[j+1]  = vld_reg;
    end

    assign quot     = q_w[NS];
    assign rem      = rem_w[NS];
    assign len_out  = len_w[NS];
    assign side_out = side_w[NS];
    assign vld_out  = vld_w[NS];

endmodule

`default_nettype wire

@@ design/triangle_unit_normal_and_area.sv @@
// triangle_unit_normal_and_area: top level, cross product, squares and output stage
// depends on tnna_pkg, tnna_isqrt and tnna_udiv
//
// Accepts one triangle per clock while in_ready is high and returns one result per request, in order.
// The pipeline holds six stages for edges, cross product and squared length, one per
// root bit of the square root, one per quotient bit of the divider, and the output
// register. The whole pipeline advances together whenever the output register is empty
// or being taken, so a held result stalls input only while the output is not ready.
// min_length is written through cfg_we / cfg_wdata; the user must write it only while
// no request is in flight, as the block itself does not enforce this.
`default_nettype none

module triangle_unit_normal_and_area
    import tnna_pkg::*;
#(
    parameter int COORD_WIDTH    = 16,
    parameter int UNIT_FRAC_BITS = 15
)
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire  signed [COORD_WIDTH-1:0] a_x,
    input  wire  signed [COORD_WIDTH-1:0] a_y,
    input  wire  signed [COORD_WIDTH-1:0] a_z,
    input  wire  signed [COORD_WIDTH-1:0] b_x,
    input  wire  signed [COORD_WIDTH-1:0] b_y,
    input  wire  signed [COORD_WIDTH-1:0] b_z,
    input  wire  signed [COORD_WIDTH-1:0] c_x,
    input  wire  signed [COORD_WIDTH-1:0] c_y,
    input  wire  signed [COORD_WIDTH-1:0] c_z,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic signed [OUT_W-1:0]       unit_x,
    output logic signed [OUT_W-1:0]       unit_y,
    output logic signed [OUT_W-1:0]       unit_z,
    output logic [AREA_W-1:0]             area,
    output logic                          degenerate,
    input  wire                           cfg_we,
    input  wire  [MINLEN_W-1:0]           cfg_wdata
);

    localparam int E_W    = COORD_WIDTH + 1;
    localparam int P_W    = 2 * E_W;
    localparam int N_W    = 2 * COORD_WIDTH + 2;
    localparam int MAG_W  = 2 * COORD_WIDTH + 1;
    localparam int LO_W   = (MAG_W + 1) / 2;
    localparam int HI_W   = MAG_W - LO_W;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int L_W    = MAG_W + 1;
    localparam int RAD_W  = 2 * L_W;
    localparam int F      = UNIT_FRAC_BITS;
    localparam int CMP_W  = (L_W > MINLEN_W) ? L_W : MINLEN_W;
    localparam int AX_W   = (L_W - 1 > AREA_W) ? L_W - 1 : AREA_W;
    localparam int SW     = (F + 2 > OUT_W) ? F + 2 : OUT_W;
    localparam int SQS_W  = 3 * MAG_W + 3 + 3 * OUT_W;
    localparam int DVS_W  = 3 + 3 * OUT_W + AREA_W + 1;

    localparam logic signed [N_W-1:0] RAW_HI = {{(N_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [N_W-1:0] RAW_LO = {{(N_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};
    localparam logic [F+1:0]          FULL   = (F+2)'(1) << F;

    logic [MINLEN_W-1:0] min_length_reg;
    logic                en;

    // output register
    logic                    out_vld_reg;
    logic signed [OUT_W-1:0] ux_reg, uy_reg, uz_reg;
    logic [AREA_W-1:0]       area_reg;
    logic                    deg_reg;

    assign en       = out_ready || !out_vld_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            min_length_reg <= cfg_wdata;
        end
    end

    // stage 1: edges
    logic                  s1_vld_reg;
    logic signed [E_W-1:0] e1_reg [3];
    logic signed [E_W-1:0] e2_reg [3];

    // stage 2: products
    logic                  s2_vld_reg;
    logic signed [P_W-1:0] p_reg [6];

    // stage 3: cross product magnitude, sign, saturated raw
    logic                    s3_vld_reg;
    logic [MAG_W-1:0]        s3_mag_reg [3];
    logic [2:0]              s3_neg_reg;
    logic [OUT_W-1:0]        s3_raw_reg [3];
    logic [2:0][MAG_W-1:0]   mag_next;
    logic [2:0]              neg_next;
    logic [2:0][OUT_W-1:0]   raw_next;

    // stage 4: partial squares
    logic                    s4_vld_reg;
    logic [2*HI_W-1:0]       hh_reg [3];
    logic [HI_W+LO_W-1:0]    hl_reg [3];
    logic [2*LO_W-1:0]       ll_reg [3];
    logic [MAG_W-1:0]        s4_mag_reg [3];
    logic [2:0]              s4_neg_reg;
    logic [OUT_W-1:0]        s4_raw_reg [3];

    // stage 5: squares
    logic                    s5_vld_reg;
    logic [SQ_W-1:0]         sq_reg [3];
    logic [MAG_W-1:0]        s5_mag_reg [3];
    logic [2:0]              s5_neg_reg;
    logic [OUT_W-1:0]        s5_raw_reg [3];

    // stage 6: squared length
    logic                    s6_vld_reg;
    logic [RAD_W-1:0]        sum_reg;
    logic [SQS_W-1:0]        s6_side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic signed [N_W-1:0] nv;
            nv = N_W'(p_reg[2*i]) - N_W'(p_reg[2*i+1]);
            neg_next[i] = nv[N_W-1];
            mag_next[i] = nv[N_W-1] ? MAG_W'(-nv) : MAG_W'(nv);
            if (nv > RAW_HI)
            begin
                raw_next[i] = RAW_HI[OUT_W-1:0];
            end
            else if (nv < RAW_LO)
            begin
                raw_next[i] = RAW_LO[OUT_W-1:0];
            end
            else
            begin
                raw_next[i] = nv[OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg[0] <= E_W'(b_x) - E_W'(a_x);
            e1_reg[1] <= E_W'(b_y) - E_W'(a_y);
            e1_reg[2] <= E_W'(b_z) - E_W'(a_z);
            e2_reg[0] <= E_W'(c_x) - E_W'(a_x);
            e2_reg[1] <= E_W'(c_y) - E_W'(a_y);
            e2_reg[2] <= E_W'(c_z) - E_W'(a_z);

            p_reg[0] <= P_W'(e1_reg[1]) * P_W'(e2_reg[2]);
            p_reg[1] <= P_W'(e1_reg[2]) * P_W'(e2_reg[1]);
            p_reg[2] <= P_W'(e1_reg[2]) * P_W'(e2_reg[0]);
            p_reg[3] <= P_W'(e1_reg[0]) * P_W'(e2_reg[2]);
            p_reg[4] <= P_W'(e1_reg[0]) * P_W'(e2_reg[1]);
            p_reg[5] <= P_W'(e1_reg[1]) * P_W'(e2_reg[0]);

            for (int i = 0; i < 3; i++)
            begin
                s3_mag_reg[i] <= mag_next[i];
                s3_neg_reg[i] <= neg_next[i];
                s3_raw_reg[i] <= raw_next[i];

                hh_reg[i] <= (2*HI_W)'(s3_mag_reg[i][MAG_W-1:LO_W])
                           * (2*HI_W)'(s3_mag_reg[i][MAG_W-1:LO_W]);
                hl_reg[i] <= (HI_W+LO_W)'(s3_mag_reg[i][MAG_W-1:LO_W])
                           * (HI_W+LO_W)'(s3_mag_reg[i][LO_W-1:0]);
                ll_reg[i] <= (2*LO_W)'(s3_mag_reg[i][LO_W-1:0])
                           * (2*LO_W)'(s3_mag_reg[i][LO_W-1:0]);
                s4_mag_reg[i] <= s3_mag_reg[i];
                s4_neg_reg[i] <= s3_neg_reg[i];
                s4_raw_reg[i] <= s3_raw_reg[i];

                sq_reg[i] <= (SQ_W'(hh_reg[i]) << (2*LO_W))
                           + (SQ_W'(hl_reg[i]) << (LO_W+1))
                           + SQ_W'(ll_reg[i]);
                s5_mag_reg[i] <= s4_mag_reg[i];
                s5_neg_reg[i] <= s4_neg_reg[i];
                s5_raw_reg[i] <= s4_raw_reg[i];
            end

            sum_reg <= RAD_W'(sq_reg[0]) + RAD_W'(sq_reg[1]) + RAD_W'(sq_reg[2]);
            s6_side_reg <= {s5_mag_reg[2], s5_mag_reg[1], s5_mag_reg[0], s5_neg_reg,
                            s5_raw_reg[2], s5_raw_reg[1], s5_raw_reg[0]};
        end
    end

    // square root
    logic [L_W-1:0]   len;
    logic [SQS_W-1:0] sqr_side;
    logic             sqr_vld;

    tnna_isqrt #(
        .ROOT_W (L_W),
        .SIDE_W (SQS_W)
    ) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      ('{adv: en, vld: s6_vld_reg}),
        .rad      (sum_reg),
        .side     (s6_side_reg),
        .root     (len),
        .side_out (sqr_side),
        .vld_out  (sqr_vld)
    );

    logic [2:0][MAG_W-1:0] sq_mag;
    logic [2:0]            sq_neg;
    logic [2:0][OUT_W-1:0] sq_raw;
    logic                  sq_deg;
    logic [AX_W-1:0]       area_ext;
    logic [AREA_W-1:0]     sq_area;
    logic [2:0][L_W-1:0]   div_mag;

    assign {sq_mag, sq_neg, sq_raw} = sqr_side;
    assign sq_deg   = (CMP_W'(len) <= CMP_W'(min_length_reg));
    assign area_ext = AX_W'(len >> 1);
    assign sq_area  = (area_ext > AX_W'({AREA_W{1'b1}})) ? {AREA_W{1'b1}}
                                                         : area_ext[AREA_W-1:0];

    for (genvar l = 0; l < 3; l++) begin : g_dmag
        assign div_mag[l] = L_W'(sq_mag[l]);
    end

    // unit normal division
    logic [2:0][F:0]     dq;
    logic [2:0][L_W:0]   drem;
    logic [L_W-1:0]      dlen;
    logic [DVS_W-1:0]    dv_side;
    logic                dv_vld;

    tnna_udiv #(
        .LEN_W  (L_W),
        .QF     (F),
        .SIDE_W (DVS_W)
    ) u_udiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      ('{adv: en, vld: sqr_vld}),
        .mag      (div_mag),
        .len      (len),
        .side     ({sq_neg, sq_raw, sq_area, sq_deg}),
        .quot     (dq),
        .rem      (drem),
        .len_out  (dlen),
        .side_out (dv_side),
        .vld_out  (dv_vld)
    );

    logic [2:0]            dv_neg;
    logic [2:0][OUT_W-1:0] dv_raw;
    logic [AREA_W-1:0]     dv_area;
    logic                  dv_deg;
    logic [2:0][OUT_W-1:0] unit_next;

    assign {dv_neg, dv_raw, dv_area, dv_deg} = dv_side;

    // rounding, saturation of plus full scale and selection of the raw normal
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [F+1:0]   qr;
            logic           rnd;
            logic signed [SW-1:0] pos;
            logic signed [SW-1:0] val;
            rnd = ({drem[i], 1'b0} >= (L_W+2)'(dlen));
            qr  = (F+2)'(dq[i]) + (F+2)'(rnd);
            pos = SW'(qr);
            if (!dv_neg[i] && (qr >= FULL))
            begin
                pos = SW'(FULL) - SW'(1);
            end
            val = dv_neg[i] ? -pos : pos;
            unit_next[i] = dv_deg ? dv_raw[i] : val[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_reg   <= unit_next[0];
            uy_reg   <= unit_next[1];
            uz_reg   <= unit_next[2];
            area_reg <= dv_area;
            deg_reg  <= dv_deg;
        end
    end

    assign out_valid  = out_vld_reg;
    assign unit_x     = ux_reg;
    assign unit_y     = uy_reg;
    assign unit_z     = uz_reg;
    assign area       = area_reg;
    assign degenerate = deg_reg;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_vld_reg)
        else $error("accepted request missing from first stage");

    a_stall_holds_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(sqr_vld) && $stable(dv_vld))
        else $error("pipeline moved during stall");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({unit_x, unit_y, unit_z, area, degenerate}))
        else $error("held result changed");

    a_zero_len_deg: assert property (@(posedge clk) disable iff (!rst_n)
        sqr_vld && (len == '0) |-> sq_deg)
        else $error("zero length not flagged degenerate");

endmodule

`default_nettype wire
